### design/ps2sc_pkg.sv
// ps2sc_pkg: shared types, key code constants and lookup tables of the scancode decoder
`timescale 1ns / 1ps

package ps2sc_pkg;

    localparam int DEFAULT_NUM_KEY_CODES = 128;

    // raw byte codes
    localparam logic [7:0] PREFIX_EXT   = 8'hE0;
    localparam logic [7:0] PREFIX_PAUSE = 8'hE1;
    localparam logic [7:0] PRTSC_MAKE   = 8'h2A;
    localparam logic [7:0] PRTSC_BREAK  = 8'hB7;
    localparam logic [7:0] IDX_PRTSC    = 8'h6E;
    localparam logic [7:0] IDX_PAUSE    = 8'h6F;
    localparam logic [7:0] RELEASE_BIT  = 8'h80;

    // skip lengths after print screen and pause
    localparam logic [2:0] PRTSC_SKIP = 3'd2;
    localparam logic [2:0] PAUSE_SKIP = 3'd5;

    // key codes with special meaning
    localparam logic [6:0] KC_CAPS   = 7'h30;
    localparam logic [6:0] KC_LSHIFT = 7'h40;
    localparam logic [6:0] KC_RSHIFT = 7'h4B;
    localparam logic [6:0] KC_SCROLL = 7'h61;
    localparam logic [6:0] KC_PAUSE  = 7'h62;

    // lower-case letter range and case offset
    localparam logic [6:0] ASCII_LOWER_A = 7'h61;
    localparam logic [6:0] ASCII_LOWER_Z = 7'h7A;
    localparam logic [6:0] CASE_OFFSET   = 7'd32;

    typedef struct packed {
        logic       has_event;
        logic       key_released;
        logic [6:0] key_code;
    } scan_event_t;

    typedef struct packed {
        logic caps;
        logic scroll;
        logic shift_held;
    } lock_status_t;

    localparam int PLAIN_ROM_DEPTH = 89;

    localparam logic [6:0] PLAIN_ROM [PLAIN_ROM_DEPTH] = '{
        7'h00, 7'h00,
        7'h11, 7'h12, 7'h13, 7'h14, 7'h15, 7'h16, 7'h17, 7'h18, 7'h19, 7'h1A,
        7'h1B, 7'h1C, 7'h1D,
        7'h20, 7'h21, 7'h22, 7'h23, 7'h24, 7'h25, 7'h26, 7'h27, 7'h28, 7'h29,
        7'h2A, 7'h2B, 7'h2C,
        7'h3C, 7'h50,
        7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h3A,
        7'h3B,
        7'h10, 7'h40, 7'h2D,
        7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46, 7'h47, 7'h48, 7'h49, 7'h4A,
        7'h4B,
        7'h00, 7'h52, 7'h53, 7'h30,
        7'h01, 7'h02, 7'h03, 7'h04, 7'h05, 7'h06, 7'h07, 7'h08, 7'h09, 7'h0A,
        7'h00, 7'h61,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00,
        7'h0B, 7'h0C
    };

    function automatic logic [6:0] plain_lookup(input logic [6:0] idx);
        logic [6:0] kc;
        kc = 7'h00;
        if (idx < 7'(PLAIN_ROM_DEPTH))
        begin
            kc = PLAIN_ROM[idx];
        end
        return kc;
    endfunction

    function automatic logic [6:0] ext_lookup(input logic [6:0] idx);
        logic [6:0] kc;
        case (idx)
            7'h1D: kc = 7'h57;
            7'h38: kc = 7'h54;
            7'h47: kc = 7'h64;
            7'h48: kc = 7'h70;
            7'h49: kc = 7'h65;
            7'h4B: kc = 7'h71;
            7'h4D: kc = 7'h73;
            7'h4F: kc = 7'h67;
            7'h50: kc = 7'h72;
            7'h51: kc = 7'h68;
            7'h52: kc = 7'h63;
            7'h53: kc = 7'h66;
            7'h5B: kc = 7'h51;
            7'h5C: kc = 7'h55;
            7'h5D: kc = 7'h56;
            7'h6E: kc = 7'h60;
            7'h6F: kc = 7'h62;
            default: kc = 7'h00;
        endcase
        return kc;
    endfunction

    function automatic logic [6:0] base_lookup(input logic [6:0] kc);
        logic [6:0] ch;
        case (kc)
            7'h10: ch = 7'h60;
            7'h11: ch = 7'h31;
            7'h12: ch = 7'h32;
            7'h13: ch = 7'h33;
            7'h14: ch = 7'h34;
            7'h15: ch = 7'h35;
            7'h16: ch = 7'h36;
            7'h17: ch = 7'h37;
            7'h18: ch = 7'h38;
            7'h19: ch = 7'h39;
            7'h1A: ch = 7'h30;
            7'h1B: ch = 7'h2D;
            7'h1C: ch = 7'h3D;
            7'h1D: ch = 7'h08;
            7'h20: ch = 7'h09;
            7'h21: ch = 7'h71;
            7'h22: ch = 7'h77;
            7'h23: ch = 7'h65;
            7'h24: ch = 7'h72;
            7'h25: ch = 7'h74;
            7'h26: ch = 7'h79;
            7'h27: ch = 7'h75;
            7'h28: ch = 7'h69;
            7'h29: ch = 7'h6F;
            7'h2A: ch = 7'h70;
            7'h2B: ch = 7'h5B;
            7'h2C: ch = 7'h5D;
            7'h2D: ch = 7'h5C;
            7'h31: ch = 7'h61;
            7'h32: ch = 7'h73;
            7'h33: ch = 7'h64;
            7'h34: ch = 7'h66;
            7'h35: ch = 7'h67;
            7'h36: ch = 7'h68;
            7'h37: ch = 7'h6A;
            7'h38: ch = 7'h6B;
            7'h39: ch = 7'h6C;
            7'h3A: ch = 7'h3B;
            7'h3B: ch = 7'h27;
            7'h3C: ch = 7'h0A;
            7'h41: ch = 7'h7A;
            7'h42: ch = 7'h78;
            7'h43: ch = 7'h63;
            7'h44: ch = 7'h76;
            7'h45: ch = 7'h62;
            7'h46: ch = 7'h6E;
            7'h47: ch = 7'h6D;
            7'h48: ch = 7'h2C;
            7'h49: ch = 7'h2E;
            7'h4A: ch = 7'h2F;
            7'h53: ch = 7'h20;
            default: ch = 7'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [6:0] shift_lookup(input logic [6:0] kc);
        logic [6:0] ch;
        case (kc)
            7'h10: ch = 7'h7E;
            7'h11: ch = 7'h21;
            7'h12: ch = 7'h40;
            7'h13: ch = 7'h23;
            7'h14: ch = 7'h24;
            7'h15: ch = 7'h25;
            7'h16: ch = 7'h5E;
            7'h17: ch = 7'h26;
            7'h18: ch = 7'h2A;
            7'h19: ch = 7'h28;
            7'h1A: ch = 7'h29;
            7'h1B: ch = 7'h5F;
            7'h1C: ch = 7'h2B;
            7'h21: ch = 7'h51;
            7'h22: ch = 7'h57;
            7'h23: ch = 7'h45;
            7'h24: ch = 7'h52;
            7'h25: ch = 7'h54;
            7'h26: ch = 7'h59;
            7'h27: ch = 7'h55;
            7'h28: ch = 7'h49;
            7'h29: ch = 7'h4F;
            7'h2A: ch = 7'h50;
            7'h2B: ch = 7'h7B;
            7'h2C: ch = 7'h7D;
            7'h2D: ch = 7'h7C;
            7'h31: ch = 7'h41;
            7'h32: ch = 7'h53;
            7'h33: ch = 7'h44;
            7'h34: ch = 7'h46;
            7'h35: ch = 7'h47;
            7'h36: ch = 7'h48;
            7'h37: ch = 7'h4A;
            7'h38: ch = 7'h4B;
            7'h39: ch = 7'h4C;
            7'h3A: ch = 7'h3A;
            7'h3B: ch = 7'h22;
            7'h41: ch = 7'h5A;
            7'h42: ch = 7'h58;
            7'h43: ch = 7'h43;
            7'h44: ch = 7'h56;
            7'h45: ch = 7'h42;
            7'h46: ch = 7'h4E;
            7'h47: ch = 7'h4D;
            7'h48: ch = 7'h3C;
            7'h49: ch = 7'h3E;
            7'h4A: ch = 7'h3F;
            default: ch = 7'h00;
        endcase
        return ch;
    endfunction

endpackage

### design/ps2sc_prefix_parser.sv
// ps2sc_prefix_parser: prefix and skip tracking, scancode to key code mapping
`timescale 1ns / 1ps

module ps2sc_prefix_parser
    import ps2sc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  byte_in,
    output scan_event_t evt
);

    logic       ext_reg;
    logic       ext_next;
    logic [2:0] skip_reg;
    logic [2:0] skip_next;
    logic [7:0] code;
    logic       use_ext;

    always_comb
    begin
        ext_next      = ext_reg;
        skip_next     = skip_reg;
        code          = byte_in;
        use_ext       = 1'b0;
        evt.has_event = 1'b0;
        if (skip_reg != 3'd0)
        begin
            // trailing bytes of print screen or pause
            skip_next = skip_reg - 3'd1;
        end
        else if (ext_reg)
        begin
            ext_next      = 1'b0;
            use_ext       = 1'b1;
            evt.has_event = 1'b1;
            if (byte_in == PRTSC_MAKE)
            begin
                code      = IDX_PRTSC;
                skip_next = PRTSC_SKIP;
            end
            else if (byte_in == PRTSC_BREAK)
            begin
                code      = IDX_PRTSC | RELEASE_BIT;
                skip_next = PRTSC_SKIP;
            end
        end
        else if (byte_in == PREFIX_EXT)
        begin
            ext_next = 1'b1;
        end
        else if (byte_in == PREFIX_PAUSE)
        begin
            use_ext       = 1'b1;
            code          = IDX_PAUSE;
            skip_next     = PAUSE_SKIP;
            evt.has_event = 1'b1;
        end
        else
        begin
            evt.has_event = 1'b1;
        end
        evt.key_released = code[7];
        evt.key_code     = use_ext ? ext_lookup(code[6:0]) : plain_lookup(code[6:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_reg  <= 1'b0;
            skip_reg <= 3'd0;
        end
        else if (step)
        begin
            ext_reg  <= ext_next;
            skip_reg <= skip_next;
        end
    end

endmodule

### design/ps2sc_key_tracker.sv
// ps2sc_key_tracker: per-key down map and lock toggles
`timescale 1ns / 1ps

module ps2sc_key_tracker
    import ps2sc_pkg::*;
#(
    parameter int NUM_KEY_CODES = DEFAULT_NUM_KEY_CODES
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  scan_event_t  evt,
    output lock_status_t status
);

    localparam int IDX_W = $clog2(NUM_KEY_CODES);

    logic [NUM_KEY_CODES-1:0] down_reg;
    logic [NUM_KEY_CODES-1:0] down_next;
    logic                     caps_reg;
    logic                     caps_next;
    logic                     scroll_reg;
    logic                     scroll_next;
    logic                     update;
    logic                     press;

    always_comb
    begin
        update      = step && evt.has_event;
        press       = !evt.key_released;
        down_next   = down_reg;
        caps_next   = caps_reg;
        scroll_next = scroll_reg;
        if (evt.key_code != KC_PAUSE)
        begin
            down_next[IDX_W'(evt.key_code)] = press;
        end
        if (press && evt.key_code == KC_CAPS)
        begin
            caps_next = !caps_reg;
        end
        if (press && evt.key_code == KC_SCROLL)
        begin
            scroll_next = !scroll_reg;
        end
        // state as seen after this event
        status.caps       = caps_next;
        status.scroll     = scroll_next;
        status.shift_held = down_next[IDX_W'(KC_LSHIFT)] | down_next[IDX_W'(KC_RSHIFT)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            down_reg   <= '0;
            caps_reg   <= 1'b0;
            scroll_reg <= 1'b0;
        end
        else if (update)
        begin
            down_reg   <= down_next;
            caps_reg   <= caps_next;
            scroll_reg <= scroll_next;
        end
    end

endmodule

### design/ps2sc_ascii_map.sv
// ps2sc_ascii_map: key code to ascii with shift and caps lock rules
`timescale 1ns / 1ps

module ps2sc_ascii_map
    import ps2sc_pkg::*;
(
    input  scan_event_t  evt,
    input  lock_status_t status,
    output logic [6:0]   ascii
);

    logic [6:0] base_ch;

    always_comb
    begin
        base_ch = base_lookup(evt.key_code);
        if (evt.key_released)
        begin
            ascii = 7'h00;
        end
        else if (status.shift_held && !status.caps)
        begin
            ascii = shift_lookup(evt.key_code);
        end
        else if (status.caps && base_ch >= ASCII_LOWER_A && base_ch <= ASCII_LOWER_Z)
        begin
            ascii = base_ch - CASE_OFFSET;
        end
        else
        begin
            ascii = base_ch;
        end
    end

endmodule

### design/ps2_scancode_to_ascii_decoder_unit.sv
// ps2_scancode_to_ascii_decoder_unit: set-1 scancode decoder top level
`timescale 1ns / 1ps

// usage
//   scan channel (scan_valid/scan_ready/scan_byte) takes one raw keyboard byte per beat
//   key channel (key_valid/key_ready) gives one beat per decoded key event:
//     key_code, key_released, ascii_char, caps_state, scroll_state
//   the E0 prefix byte, the pause trailer and print screen trailers give no beat
// timing
//   a byte waits in the input register until one lookup pass through the prefix parser,
//   key tracker and ascii tables loads the result register
//   a key event passes through the input register and then the result register to key_valid
//   throughput is one byte per cycle unless stalled, set by the single reg-to-reg pass
// reset
//   rst_n clears the prefix flag, skip count, key down map and both lock toggles;
//   both registers come up empty
// stalls
//   while key_ready is low and a result waits, the byte in the input register holds
//   and scan_ready drops; a held result frees the path in the cycle it is taken
module ps2_scancode_to_ascii_decoder_unit
    import ps2sc_pkg::*;
#(
    parameter int NUM_KEY_CODES = DEFAULT_NUM_KEY_CODES
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       scan_valid,
    output logic       scan_ready,
    input  logic [7:0] scan_byte,
    output logic       key_valid,
    input  logic       key_ready,
    output logic [6:0] key_code,
    output logic       key_released,
    output logic [6:0] ascii_char,
    output logic       caps_state,
    output logic       scroll_state
);

    // input register
    logic       byte_valid_reg;
    logic [7:0] byte_reg;

    // result register
    logic       out_valid_reg;
    logic [6:0] code_reg;
    logic       rel_reg;
    logic [6:0] ascii_reg;
    logic       caps_reg;
    logic       scroll_reg;

    logic         out_free;
    logic         step;
    scan_event_t  evt;
    lock_status_t status;
    logic [6:0]   ascii;

    // result slot is open when empty or being taken this cycle
    assign out_free   = !out_valid_reg || key_ready;
    assign step       = byte_valid_reg && out_free;
    assign scan_ready = !byte_valid_reg || out_free;

    ps2sc_prefix_parser u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .byte_in (byte_reg),
        .evt     (evt)
    );

    ps2sc_key_tracker #(
        .NUM_KEY_CODES (NUM_KEY_CODES)
    ) u_tracker
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .evt    (evt),
        .status (status)
    );

    ps2sc_ascii_map u_ascii
    (
        .evt    (evt),
        .status (status),
        .ascii  (ascii)
    );

    // input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
        end
        else if (scan_ready)
        begin
            byte_valid_reg <= scan_valid;
        end
    end

    // input stage payload
    always_ff @(posedge clk)
    begin
        if (scan_valid && scan_ready)
        begin
            byte_reg <= scan_byte;
        end
    end

    // result stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= step && evt.has_event;
        end
    end

    // result stage payload
    always_ff @(posedge clk)
    begin
        if (step && evt.has_event)
        begin
            code_reg   <= evt.key_code;
            rel_reg    <= evt.key_released;
            ascii_reg  <= ascii;
            caps_reg   <= status.caps;
            scroll_reg <= status.scroll;
        end
    end

    assign key_valid    = out_valid_reg;
    assign key_code     = code_reg;
    assign key_released = rel_reg;
    assign ascii_char   = ascii_reg;
    assign caps_state   = caps_reg;
    assign scroll_state = scroll_reg;

endmodule
